>>> hdl/binary_trie_prefix_match_unit_assert.svh
// ----------------------------------------------------------------------------
// Binary trie prefix match unit: assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BINARY_TRIE_PREFIX_MATCH_UNIT_ASSERT_SVH
`define BINARY_TRIE_PREFIX_MATCH_UNIT_ASSERT_SVH

// same-cycle implication
`define BTPM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BTPM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// invariant
`define BTPM_ASSERT_ALW(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

`endif

>>> hdl/btpm_pkg.sv
// ----------------------------------------------------------------------------
// btpm_pkg
// Types, constants and codes shared by the binary trie prefix match unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package btpm_pkg;

	localparam int NODE_COUNT = 4096;
	localparam int IDX_W      = $clog2(NODE_COUNT);
	localparam int USED_W     = IDX_W + 1;
	localparam int HOP_BITS   = 16;
	localparam int ADDR_W     = 32;
	localparam int LEN_W      = 6;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [HOP_BITS-1:0] hop_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BADLEN  = 2'd1,
		ST_FULL    = 2'd2,
		ST_NOMATCH = 2'd3
	} status_t;

	typedef struct packed {
		logic              command;
		logic [ADDR_W-1:0] address;
		logic [LEN_W-1:0]  prefix_len;
		hop_t              next_hop;
	} in_req_t;

	typedef struct packed {
		status_t status;
		hop_t    hop_found;
	} out_rsp_t;

	typedef struct packed {
		idx_t left;
		idx_t right;
		hop_t hop;
		logic valid;
	} node_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_STEP,
		S_LINK,
		S_FINAL,
		S_RESP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;
		logic    visit;
		logic    descend;
		logic    alloc;
		logic    link;
		logic    final_wr;
		logic    out_load;
		status_t rsp_code;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_bad;
		logic is_lookup;
		logic level_done;
		logic child_zero;
		logic pool_full;
		logic found;
		logic out_busy;
	} dp_sts_t;

endpackage

`default_nettype wire

>>> hdl/binary_trie_prefix_match_unit.sv
// ----------------------------------------------------------------------------
// binary_trie_prefix_match_unit
// IPv4 longest-prefix match on a unibit trie held in a 4096-entry node memory.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel in_valid/in_stall/in_data: command 0 inserts the top
//   prefix_len bits of address with next_hop, command 1 looks up address.
//   Response channel out_valid/out_stall/out_data returns one response per
//   request: status and hop_found (zero unless a lookup matched).
//   After acceptance the walk visits one trie level per step, visiting up to 33
//   levels on a full 32-bit lookup (one node memory read per level below the
//   root); an insert adds a parent-link step for each node that it allocates,
//   then writes the final hop, and the response is loaded last. One request at a time.
//   The response sits in an output register, so the next request is taken
//   while it waits. If out_stall holds it, a finished walk waits in the
//   response state and in_stall stays high.
//   Reset leaves an empty trie (root with no children, one node in use);
//   the node memory itself needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module binary_trie_prefix_match_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire btpm_pkg::in_req_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output btpm_pkg::out_rsp_t      out_data
);

	btpm_pkg::dp_cmd_t ctl;
	btpm_pkg::dp_sts_t sts;
	logic [3:0]        mem_ops;

	assign mem_ops = {ctl.descend, ctl.alloc, ctl.link, ctl.final_wr};

	btpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	btpm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.ctl       (ctl),
		.sts       (sts),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

`include "binary_trie_prefix_match_unit_assert.svh"

	// at most one memory access per cycle
	`BTPM_ASSERT_ALW(a_mem_port_excl, $onehot0(mem_ops), "node memory port conflict")
	// a taken request blocks the next one
	`BTPM_ASSERT_NXT(a_load_stalls, ctl.load, in_stall, "request taken while busy")
	// never allocate past the pool
	`BTPM_ASSERT_IMP(a_alloc_room, ctl.alloc, !sts.pool_full, "allocation from full pool")
	// a response is never loaded over one still held
	`BTPM_ASSERT_IMP(a_rsp_no_clobber, ctl.out_load, !(out_valid && out_stall), "response overwritten")

endmodule

`default_nettype wire

>>> hdl/btpm_ctrl.sv
// ----------------------------------------------------------------------------
// btpm_ctrl
// Sequencer for trie walks: insert, lookup and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btpm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire btpm_pkg::dp_sts_t sts,
	output btpm_pkg::dp_cmd_t      ctl
);

	btpm_pkg::state_t  state_q, state_d;
	btpm_pkg::status_t code_q, code_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btpm_pkg::S_IDLE;
			code_q  <= btpm_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		case (state_q)
			btpm_pkg::S_IDLE: begin
				if (in_valid) begin
					if (sts.in_bad) begin
						code_d  = btpm_pkg::ST_BADLEN;
						state_d = btpm_pkg::S_RESP;
					end else begin
						code_d  = btpm_pkg::ST_OK;
						state_d = btpm_pkg::S_STEP;
					end
				end
			end
			btpm_pkg::S_STEP: begin
				if (sts.level_done) begin
					state_d = sts.is_lookup ? btpm_pkg::S_RESP : btpm_pkg::S_FINAL;
				end else if (!sts.child_zero) begin
					state_d = btpm_pkg::S_STEP;
				end else if (sts.is_lookup) begin
					state_d = btpm_pkg::S_RESP;
				end else if (sts.pool_full) begin
					code_d  = btpm_pkg::ST_FULL;
					state_d = btpm_pkg::S_RESP;
				end else begin
					state_d = btpm_pkg::S_LINK;
				end
			end
			btpm_pkg::S_LINK: begin
				state_d = btpm_pkg::S_STEP;
			end
			btpm_pkg::S_FINAL: begin
				code_d  = btpm_pkg::ST_OK;
				state_d = btpm_pkg::S_RESP;
			end
			btpm_pkg::S_RESP: begin
				if (!sts.out_busy) begin
					state_d = btpm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = btpm_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl          = '0;
		ctl.rsp_code = code_q;
		in_stall     = 1'b1;
		case (state_q)
			btpm_pkg::S_IDLE: begin
				in_stall = 1'b0;
				ctl.load = in_valid;
			end
			btpm_pkg::S_STEP: begin
				ctl.visit = 1'b1;
				if (!sts.level_done) begin
					if (!sts.child_zero) begin
						ctl.descend = 1'b1;
					end else if (!sts.is_lookup && !sts.pool_full) begin
						ctl.alloc = 1'b1;
					end
				end
			end
			btpm_pkg::S_LINK: begin
				ctl.link = 1'b1;
			end
			btpm_pkg::S_FINAL: begin
				ctl.final_wr = 1'b1;
			end
			btpm_pkg::S_RESP: begin
				ctl.out_load = !sts.out_busy;
				if (sts.is_lookup) begin
					ctl.rsp_code = sts.found ? btpm_pkg::ST_OK : btpm_pkg::ST_NOMATCH;
				end
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/btpm_datapath.sv
// ----------------------------------------------------------------------------
// btpm_datapath
// Node memory, root links, walk registers, pool counter and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btpm_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire btpm_pkg::in_req_t in_data,
	input  wire btpm_pkg::dp_cmd_t ctl,
	output btpm_pkg::dp_sts_t      sts,
	input  wire logic              out_stall,
	output logic                   out_valid,
	output btpm_pkg::out_rsp_t     out_data
);

	// node 0 (root) lives in flops; memory entries are only read once linked
	btpm_pkg::node_t mem [btpm_pkg::NODE_COUNT];
	btpm_pkg::node_t rdata_q;
	btpm_pkg::node_t ent_q;
	btpm_pkg::node_t ent_sel;
	btpm_pkg::node_t linked;
	btpm_pkg::node_t wr_data;

	logic                        from_mem_q;
	logic [btpm_pkg::USED_W-1:0] used_q;
	btpm_pkg::idx_t              root_left_q, root_right_q;
	btpm_pkg::idx_t              cur_q;
	btpm_pkg::idx_t              child;
	btpm_pkg::idx_t              new_idx;
	btpm_pkg::idx_t              wr_addr;
	logic                        wr_en;
	logic                        found_q;
	btpm_pkg::hop_t              best_q;
	logic                        cmd_q;
	logic [btpm_pkg::ADDR_W-1:0] addr_q;
	logic [btpm_pkg::LEN_W-1:0]  len_q;
	logic [btpm_pkg::LEN_W-1:0]  level_q;
	btpm_pkg::hop_t              hop_q;
	logic                        dir_bit;
	logic                        is_lookup;
	logic                        out_valid_q;
	btpm_pkg::out_rsp_t          out_data_q;

	assign is_lookup = (cmd_q == btpm_pkg::CMD_LOOKUP);
	assign ent_sel   = from_mem_q ? rdata_q : ent_q;
	assign dir_bit   = addr_q[btpm_pkg::ADDR_W-1];
	assign child     = dir_bit ? ent_sel.right : ent_sel.left;
	assign new_idx   = used_q[btpm_pkg::IDX_W-1:0];

	always_comb begin
		linked = ent_sel;
		if (dir_bit) begin
			linked.right = new_idx;
		end else begin
			linked.left = new_idx;
		end
	end

	// single write port: new node, parent link, or final hop
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_q;
		wr_data = ent_sel;
		if (ctl.alloc) begin
			wr_en   = 1'b1;
			wr_addr = new_idx;
			wr_data = '0;
		end else if (ctl.link && (cur_q != '0)) begin
			wr_en   = 1'b1;
			wr_data = linked;
		end else if (ctl.final_wr) begin
			wr_en         = 1'b1;
			wr_data.hop   = hop_q;
			wr_data.valid = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.descend) begin
			rdata_q <= mem[child];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			from_mem_q   <= 1'b0;
			used_q       <= btpm_pkg::USED_W'(1);
			root_left_q  <= '0;
			root_right_q <= '0;
			found_q      <= 1'b0;
			cur_q        <= '0;
			level_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (ctl.load) begin
				from_mem_q <= 1'b0;
				found_q    <= 1'b0;
				cur_q      <= '0;
				level_q    <= '0;
			end else if (ctl.descend) begin
				from_mem_q <= 1'b1;
				cur_q      <= child;
				level_q    <= level_q + 1'b1;
			end else if (ctl.link) begin
				from_mem_q <= 1'b0;
				cur_q      <= new_idx;
				level_q    <= level_q + 1'b1;
				used_q     <= used_q + 1'b1;
				if (cur_q == '0) begin
					if (dir_bit) begin
						root_right_q <= new_idx;
					end else begin
						root_left_q <= new_idx;
					end
				end
			end
			if (ctl.visit && is_lookup && from_mem_q && rdata_q.valid) begin
				found_q <= 1'b1;
			end
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q     <= in_data.command;
			addr_q    <= in_data.address;
			len_q     <= in_data.prefix_len;
			hop_q     <= in_data.next_hop;
			best_q    <= '0;
			ent_q     <= '{left: root_left_q, right: root_right_q, hop: '0, valid: 1'b0};
		end else if (ctl.descend) begin
			addr_q <= {addr_q[btpm_pkg::ADDR_W-2:0], 1'b0};
		end else if (ctl.link) begin
			addr_q <= {addr_q[btpm_pkg::ADDR_W-2:0], 1'b0};
			ent_q  <= '0;
		end
		if (ctl.visit && is_lookup && from_mem_q && rdata_q.valid) begin
			best_q <= rdata_q.hop;
		end
		if (ctl.out_load) begin
			out_data_q.status    <= ctl.rsp_code;
			out_data_q.hop_found <= (is_lookup && (ctl.rsp_code == btpm_pkg::ST_OK)) ?
				best_q : '0;
		end
	end

	assign sts.in_bad     = (in_data.command == btpm_pkg::CMD_INSERT) &&
		((in_data.prefix_len == '0) ||
		(in_data.prefix_len > btpm_pkg::LEN_W'(btpm_pkg::ADDR_W - 1)));
	assign sts.is_lookup  = is_lookup;
	assign sts.level_done = is_lookup ? (level_q == btpm_pkg::LEN_W'(btpm_pkg::ADDR_W))
		: (level_q == len_q);
	assign sts.child_zero = (child == '0);
	assign sts.pool_full  = (used_q == btpm_pkg::USED_W'(btpm_pkg::NODE_COUNT));
	assign sts.found      = found_q;
	assign sts.out_busy   = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire
